@@ hdl/shp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package shp_pkg;

  localparam int PIX_W      = 8;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int FIFO_DEPTH = 2;

  localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);
  localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_KERNEL_MODE  = 2'd2
  } cfg_idx_e;

  typedef logic [PIX_W-1:0] pix_t;

  // Window rows run from two rows above (index 0) to the newest row (index 2);
  // columns run the same way from oldest to newest.
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  typedef struct packed {
    win_t win;
    logic right;
    logic bottom;
  } shp_job_t;

  typedef struct packed {
    logic [COL_W-1:0] col_last;
    logic [ROW_W-1:0] row_last;
    logic             restart;
  } shp_geom_t;

endpackage

`default_nettype wire

@@ hdl/shp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface shp_pix_if import shp_pkg::*; ();
  logic valid;
  logic ready;
  pix_t pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

interface shp_res_if import shp_pkg::*; ();
  logic valid;
  logic ready;
  pix_t pixel_out;
  logic last_of_run;
  logic frame_done;

  modport source (output valid, output pixel_out, output last_of_run, output frame_done,
                  input ready);
  modport sink (input valid, input pixel_out, input last_of_run, input frame_done,
                output ready);
endinterface

`default_nettype wire

@@ hdl/sharpen_3x3_edge_clamp.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Streaming 3x3 sharpening filter for 8-bit grey frames sent in raster order.
// Pixels enter on pix_i and sharpened pixels leave on res_o, both valid/ready
// channels; a request moves when valid and ready are high at a clock edge.
// Frame width, frame height and kernel mode are set through the write port; the user must write
// them only while the block is idle, which the block does not enforce. Writing width or height
// restarts the frame. A pixel that completes a neighborhood passes the input register and the
// queue before its result is registered. The block takes one pixel per cycle while the queue has
// room. A pixel on the right edge or in the last row releases up to four results, one per cycle
// while the receiver is ready, and input stalls once the queue fills during such bursts.
// Line memory holds the two previous rows, with one read and one write per
// cycle; a two-entry queue separates the input side from the kernel side.
// When the receiver stalls, the output holds and the queue fills, after which
// input ready drops. Reset clears counters, queue and output valid and loads
// width 640, height 480 and the four-neighbor kernel; line memory is not
// cleared, since each entry is written before it is read.
module sharpen_3x3_edge_clamp import shp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  shp_pix_if.sink               pix_i,
  shp_res_if.source             res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [FW_W-1:0] frame_width_q;
  logic [FH_W-1:0] frame_height_q;
  logic            kernel_mode_q;
  logic            restart;
  shp_geom_t       geom;
  logic            fifo_full, push, pop, head_valid;
  shp_job_t        job, head;

  always_comb begin
    restart = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_WIDTH:  restart = 1'b1;
        CFG_FRAME_HEIGHT: restart = 1'b1;
        default:          restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FW_RESET;
      frame_height_q <= FH_RESET;
      kernel_mode_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[FW_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[FH_W-1:0];
        CFG_KERNEL_MODE:  kernel_mode_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Sizes outside the supported range are saturated to it.
  always_comb begin
    if (frame_width_q < FW_W'(2)) begin
      geom.col_last = COL_W'(1);
    end else if (frame_width_q > FW_W'(MAX_WIDTH)) begin
      geom.col_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      geom.col_last = COL_W'(frame_width_q - 1'b1);
    end
    if (frame_height_q < FH_W'(2)) begin
      geom.row_last = ROW_W'(1);
    end else if (frame_height_q > FH_W'(MAX_HEIGHT)) begin
      geom.row_last = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      geom.row_last = ROW_W'(frame_height_q - 1'b1);
    end
    geom.restart = restart;
  end

  shp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_i       (pix_i),
    .geom_i      (geom),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .job_o       (job)
  );

  shp_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .job_i        (job),
    .full_o       (fifo_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  shp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .mode_i       (kernel_mode_q),
    .res_o        (res_o)
  );

endmodule

`default_nettype wire

@@ hdl/shp_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module shp_fifo import shp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  shp_job_t job_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     head_valid_o,
  output shp_job_t head_o
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  shp_job_t           mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   count_q;
  logic               do_push, do_pop;

  assign full_o       = (count_q == CNT_W'(FIFO_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

@@ hdl/shp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module shp_front import shp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  shp_pix_if.sink   pix_i,
  input  shp_geom_t geom_i,
  input  logic      fifo_full_i,
  output logic      push_o,
  output shp_job_t  job_o
);

  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];

  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic               s1_valid_q, s1_valid_d;
  pix_t               s1_pix_q;
  logic [COL_W-1:0]   s1_col_q;
  logic [ROW_W-1:0]   s1_row_q;
  logic [2*PIX_W-1:0] rd_q;
  win_t               win_q, win_d;

  logic               acc, emit, s1_adv;
  pix_t               top_px, mid_px;
  pix_t [2:0]         col_px;

  assign acc         = pix_i.valid && pix_i.ready;
  assign emit        = (s1_row_q != '0) && (s1_col_q != '0);
  assign s1_adv      = s1_valid_q && (!emit || !fifo_full_i);
  assign pix_i.ready = !s1_valid_q || s1_adv;

  // Each line entry holds the pixel two rows up in the upper byte and one row up in the lower.
  always_comb begin
    if (s1_row_q == '0) begin
      mid_px = s1_pix_q;
      top_px = s1_pix_q;
    end else begin
      mid_px = rd_q[PIX_W-1:0];
      top_px = (s1_row_q >= ROW_W'(2)) ? rd_q[2*PIX_W-1:PIX_W] : mid_px;
    end
    col_px[0] = top_px;
    col_px[1] = mid_px;
    col_px[2] = s1_pix_q;
    for (int i = 0; i < 3; i++) begin
      if (s1_col_q == '0) begin
        win_d[i][0] = col_px[i];
        win_d[i][1] = col_px[i];
      end else begin
        win_d[i][0] = win_q[i][1];
        win_d[i][1] = win_q[i][2];
      end
      win_d[i][2] = col_px[i];
    end
  end

  assign push_o = s1_adv && emit;
  always_comb begin
    job_o.win    = win_d;
    job_o.right  = (s1_col_q == geom_i.col_last);
    job_o.bottom = (s1_row_q == geom_i.row_last);
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (geom_i.restart) begin
      col_d = '0;
      row_d = '0;
    end else if (acc) begin
      if (col_q == geom_i.col_last) begin
        col_d = '0;
        row_d = (row_q == geom_i.row_last) ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
    if (acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      win_q      <= '0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
      if (s1_adv) begin
        win_q <= win_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_pix_q <= pix_i.pixel_in;
      s1_col_q <= col_q;
      s1_row_q <= row_q;
    end
  end

  // Consecutive pixels always sit in different columns, so the read of the
  // new pixel never meets the write of the one before it.
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      line_mem[s1_col_q] <= {rd_q[PIX_W-1:0], s1_pix_q};
    end
    if (acc) begin
      rd_q <= line_mem[col_q];
    end
  end

endmodule

`default_nettype wire

@@ hdl/shp_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module shp_back import shp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  shp_job_t  head_i,
  output logic      pop_o,
  input  logic      mode_i,
  shp_res_if.source res_o
);

  typedef enum logic [1:0] {
    K_CENTER = 2'd0,
    K_RIGHT  = 2'd1,
    K_BELOW  = 2'd2,
    K_CORNER = 2'd3
  } kind_e;

  kind_e  kind_q, kind_next;
  logic   run_end, adv, row_sel, col_sel;
  logic   out_valid_q, out_last_q, out_done_q;
  pix_t   out_pix_q, result;
  win_t   sel;
  logic [PIX_W+1:0] cross_sum, corner_sum;
  logic [PIX_W+2:0] neg_sum;
  logic [PIX_W+3:0] ctr_term;
  logic signed [PIX_W+4:0] total;

  assign adv     = head_valid_i && (!out_valid_q || res_o.ready);
  assign row_sel = (kind_q == K_BELOW) || (kind_q == K_CORNER);
  assign col_sel = (kind_q == K_RIGHT) || (kind_q == K_CORNER);

  always_comb begin
    kind_next = K_CENTER;
    run_end   = 1'b1;
    case (kind_q)
      K_CENTER: begin
        if (head_i.right) begin
          kind_next = K_RIGHT;
          run_end   = 1'b0;
        end else if (head_i.bottom) begin
          kind_next = K_BELOW;
          run_end   = 1'b0;
        end
      end
      K_RIGHT: begin
        if (head_i.bottom) begin
          kind_next = K_BELOW;
          run_end   = 1'b0;
        end
      end
      K_BELOW: begin
        if (head_i.right) begin
          kind_next = K_CORNER;
          run_end   = 1'b0;
        end
      end
      default: begin
        kind_next = K_CENTER;
        run_end   = 1'b1;
      end
    endcase
  end

  // Pixels on the last row or column see the edge pixel repeated in place of
  // the missing neighbor.
  always_comb begin : select_window
    logic [1:0] ri, cj;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        ri = row_sel ? ((i == 0) ? 2'd1 : 2'd2) : 2'(i);
        cj = col_sel ? ((j == 0) ? 2'd1 : 2'd2) : 2'(j);
        sel[i][j] = head_i.win[ri][cj];
      end
    end
  end

  always_comb begin
    cross_sum  = (PIX_W+2)'(sel[0][1]) + (PIX_W+2)'(sel[1][0])
               + (PIX_W+2)'(sel[1][2]) + (PIX_W+2)'(sel[2][1]);
    corner_sum = (PIX_W+2)'(sel[0][0]) + (PIX_W+2)'(sel[0][2])
               + (PIX_W+2)'(sel[2][0]) + (PIX_W+2)'(sel[2][2]);
    neg_sum    = (PIX_W+3)'(cross_sum) + (mode_i ? (PIX_W+3)'(corner_sum) : '0);
    ctr_term   = mode_i ? ((PIX_W+4)'(sel[1][1]) << 3) + (PIX_W+4)'(sel[1][1])
                        : ((PIX_W+4)'(sel[1][1]) << 2) + (PIX_W+4)'(sel[1][1]);
    total      = $signed({1'b0, ctr_term}) - $signed({2'b00, neg_sum});
    if (total[PIX_W+4]) begin
      result = '0;
    end else if (total[PIX_W+3:PIX_W] != '0) begin
      result = '1;
    end else begin
      result = total[PIX_W-1:0];
    end
  end

  assign pop_o = adv && run_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q      <= K_CENTER;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        kind_q      <= kind_next;
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_pix_q  <= result;
      out_last_q <= run_end;
      out_done_q <= (kind_q == K_CORNER);
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.pixel_out   = out_pix_q;
  assign res_o.last_of_run = out_last_q;
  assign res_o.frame_done  = out_done_q;

endmodule

`default_nettype wire

@@ hdl/shp_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module shp_checker import shp_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input pix_t pixel_out_i,
  input logic last_i,
  input logic done_i
);

  logic seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (in_valid_i && in_ready_i) begin
      seen_q <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable({pixel_out_i, last_i, done_i}))
    else $error("result changed while stalled");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && done_i |-> last_i)
    else $error("frame end not at end of burst");

  a_burst_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_i |=> out_valid_i)
    else $error("burst broken before its last result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> seen_q)
    else $error("result without any input");

endmodule

bind sharpen_3x3_edge_clamp shp_checker u_shp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .pixel_out_i (res_o.pixel_out),
  .last_i      (res_o.last_of_run),
  .done_i      (res_o.frame_done)
);

`default_nettype wire
